// ===== src/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 256;
    localparam int KEY_CHARS_DEF   = 8;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int KEY_W  = 64;
    localparam int MODE_W = 3;
    localparam int ST_W   = 3;

    typedef enum logic [2:0] {
        MD_INSERT = 3'd0,
        MD_ERASE  = 3'd1,
        MD_SEARCH = 3'd2,
        MD_FIRST  = 3'd3,
        MD_NEXT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_ERASED    = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5,
        ST_NO_ENTRY  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MK_EMPTY = 2'd0,
        MK_USED  = 2'd1,
        MK_TOMB  = 2'd2
    } t_mark;

    localparam logic [0:0] REG_CAPACITY = 1'b0;

endpackage

// ===== src/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed key/value table with linear probing and tombstones.
// Steps: insert/erase/search hash the key characters, reduce the hash modulo
// the capacity bit by bit, read and check each probed slot, then write and
// output; first/next read and check each scanned slot, then output.
// Throughput: one transaction in work at a time; a finished result waits in
// the output register while the next transaction is taken and processed.
// Reset: a clearing pass marks all TABLE_SLOTS entries empty, one per cycle;
// no input transaction is taken until it ends.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_CHARS   = lpht_pkg::KEY_CHARS_DEF,
    parameter int VALUE_BITS  = lpht_pkg::VALUE_BITS_DEF,
    localparam int SW = $clog2(TABLE_SLOTS),
    localparam int CW = SW + 1,
    localparam int IN_W = ((3 + 64 + VALUE_BITS) + 7) / 8 * 8,
    localparam int OUT_W = ((3 + SW + 64 + VALUE_BITS) + 7) / 8 * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [0:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[2:0], key[66:3], value
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status[2:0], slot, key_out, value_out
    output logic [OUT_W-1:0]  m_axis_tdata
);
    import lpht_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_MOD   = 9'b000001000,
        S_READ  = 9'b000010000,
        S_CHECK = 9'b000100000,
        S_WRITE = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_SCAN  = 9'b100000000
    } t_state;

    logic [1:0]            mem_mark  [TABLE_SLOTS];
    logic [KEY_W-1:0]      mem_key   [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] mem_val   [TABLE_SLOTS];

    t_state                r_state;
    logic [8:0]            r_cap;
    logic [CW-1:0]         r_cnt_clr;
    t_mode                 r_mode;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [63:0]           r_hash;
    logic [3:0]            r_ci;
    logic                  r_hend;
    logic [6:0]            r_mi;
    logic [CW-1:0]         r_rem;
    logic [SW-1:0]         r_idx;
    logic [CW-1:0]         r_n;
    logic                  r_tseen;
    logic [SW-1:0]         r_tomb;
    logic [1:0]            r_rd_mark;
    logic [KEY_W-1:0]      r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;
    logic [8:0]            r_count;
    logic [SW-1:0]         r_cur;
    logic                  r_cur_v;
    logic                  r_we;
    logic [SW-1:0]         r_waddr;
    logic [1:0]            r_wmark;
    logic                  r_wfull;
    t_status               r_st;
    logic [SW-1:0]         r_oslot;
    logic [KEY_W-1:0]      r_okey;
    logic [VALUE_BITS-1:0] r_oval;
    logic                  r_ovalid;
    logic [OUT_W-1:0]      r_odata;

    logic [CW-1:0]         w_cap;
    logic                  w_in_acc;
    logic [7:0]            w_ch;
    logic [7:0]            w_lc;
    logic [CW:0]           w_rem2;
    logic [CW:0]           w_sub;
    logic [SW-1:0]         w_nidx;
    logic                  w_eqk;
    logic [KEY_W-1:0]      w_nkey;
    logic                  w_kon;

    always_comb begin
        if (r_cap == 9'd0) begin
            w_cap = CW'(1);
        end else if ({23'd0, r_cap} > TABLE_SLOTS) begin
            w_cap = CW'(TABLE_SLOTS);
        end else begin
            w_cap = CW'(r_cap);
        end
    end

    // key ends at its first zero character
    always_comb begin
        w_nkey = '0;
        w_kon  = 1'b1;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (s_axis_tdata[3 + 8*i +: 8] == 8'd0) w_kon = 1'b0;
            if (w_kon) w_nkey[8*i +: 8] = s_axis_tdata[3 + 8*i +: 8];
        end
    end

    assign pready = 1'b1;
    assign prdata = {23'd0, r_cap};
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;

    assign w_ch = r_key[8*r_ci[2:0] +: 8];
    assign w_lc = (w_ch >= 8'h41 && w_ch <= 8'h5A) ? w_ch + 8'h20 : w_ch;
    assign w_rem2 = {r_rem, r_hash[63]};
    assign w_sub = w_rem2 - {1'b0, w_cap};
    assign w_nidx = ({1'b0, r_idx} + 1'b1 >= w_cap) ? '0 : r_idx + 1'b1;
    assign w_eqk = (r_rd_key == r_key);

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem_mark[r_waddr] <= r_wmark;
            if (r_wfull) begin
                mem_key[r_waddr] <= r_key;
                mem_val[r_waddr] <= r_val;
            end
        end
        r_rd_mark <= mem_mark[r_idx];
        r_rd_key  <= mem_key[r_idx];
        r_rd_val  <= mem_val[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cap     <= 9'd256;
            r_cnt_clr <= '0;
            r_count   <= '0;
            r_cur     <= '0;
            r_cur_v   <= 1'b0;
            r_ovalid  <= 1'b0;
            r_we      <= 1'b1;
            r_waddr   <= '0;
            r_wmark   <= MK_EMPTY;
            r_wfull   <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == REG_CAPACITY)
                r_cap <= pwdata[8:0];
            if (m_axis_tvalid && m_axis_tready && r_state != S_OUT)
                r_ovalid <= 1'b0;
            r_we    <= 1'b0;
            r_wfull <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_we      <= 1'b1;
                    r_waddr   <= r_cnt_clr[SW-1:0];
                    r_wmark   <= MK_EMPTY;
                    r_cnt_clr <= r_cnt_clr + 1'b1;
                    if (r_cnt_clr == CW'(TABLE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_mode  <= t_mode'(s_axis_tdata[2:0]);
                        r_key   <= w_nkey;
                        r_val   <= s_axis_tdata[67 +: VALUE_BITS];
                        r_hash  <= '0;
                        r_ci    <= '0;
                        r_hend  <= 1'b0;
                        r_tseen <= 1'b0;
                        r_n     <= '0;
                        r_st    <= ST_NO_ENTRY;
                        r_oslot <= '0;
                        r_okey  <= '0;
                        r_oval  <= '0;
                        case (s_axis_tdata[2:0])
                            MD_INSERT, MD_ERASE, MD_SEARCH: r_state <= S_HASH;
                            MD_FIRST: begin
                                r_idx   <= '0;
                                r_state <= S_SCAN;
                            end
                            MD_NEXT: begin
                                if (r_cur_v && {1'b0, r_cur} + 1'b1 < w_cap) begin
                                    r_idx   <= r_cur + 1'b1;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_HASH: begin
                    if (r_ci == 4'd8 || w_ch == 8'd0 || r_hend) begin
                        r_state <= S_MOD;
                        r_mi    <= '0;
                        r_rem   <= '0;
                    end else begin
                        r_hash <= (r_hash << 5) + r_hash + {56'd0, w_lc};
                        r_ci   <= r_ci + 1'b1;
                    end
                end
                S_MOD: begin
                    if (w_sub[CW] == 1'b0) r_rem <= w_sub[CW-1:0];
                    else r_rem <= w_rem2[CW-1:0];
                    r_hash <= r_hash << 1;
                    r_mi   <= r_mi + 1'b1;
                    if (r_mi == 7'd63) begin
                        r_idx   <= (w_sub[CW] == 1'b0) ? w_sub[SW-1:0] : w_rem2[SW-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_rd_mark == MK_EMPTY || r_n == w_cap) begin
                        if (r_mode == MD_INSERT) begin
                            if (r_tseen || r_n != w_cap) begin
                                r_waddr <= r_tseen ? r_tomb : r_idx;
                                r_oslot <= r_tseen ? r_tomb : r_idx;
                                r_cur   <= r_tseen ? r_tomb : r_idx;
                                r_cur_v <= 1'b1;
                                r_we    <= 1'b1;
                                r_wfull <= 1'b1;
                                r_wmark <= MK_USED;
                                r_count <= r_count + 1'b1;
                                r_st    <= ST_INSERTED;
                            end else begin
                                r_st <= ST_FULL;
                            end
                        end else begin
                            r_st <= ST_NOT_FOUND;
                        end
                        r_state <= S_WRITE;
                    end else if (r_rd_mark == MK_USED && w_eqk) begin
                        r_cur   <= r_idx;
                        r_cur_v <= 1'b1;
                        r_oslot <= r_idx;
                        if (r_mode == MD_INSERT) begin
                            r_st <= ST_DUPLICATE;
                        end else if (r_mode == MD_ERASE) begin
                            r_st    <= ST_ERASED;
                            r_we    <= 1'b1;
                            r_waddr <= r_idx;
                            r_wmark <= MK_TOMB;
                            r_count <= r_count - 1'b1;
                        end else begin
                            r_st   <= ST_FOUND;
                            r_okey <= r_rd_key;
                            r_oval <= r_rd_val;
                        end
                        r_state <= S_WRITE;
                    end else begin
                        if (r_rd_mark == MK_TOMB && !r_tseen) begin
                            r_tseen <= 1'b1;
                            r_tomb  <= r_idx;
                        end
                        r_idx   <= w_nidx;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SCAN: r_state <= S_WRITE;
                S_WRITE: begin
                    if (r_mode == MD_FIRST || r_mode == MD_NEXT) begin
                        if (r_rd_mark == MK_USED) begin
                            r_st    <= ST_FOUND;
                            r_oslot <= r_idx;
                            r_okey  <= r_rd_key;
                            r_oval  <= r_rd_val;
                            r_cur   <= r_idx;
                            r_cur_v <= 1'b1;
                            r_state <= S_OUT;
                        end else if ({1'b0, r_idx} + 1'b1 < w_cap) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            if (r_mode == MD_FIRST) r_cur_v <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait here while the previous result is still held
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= OUT_W'({r_oval, r_okey, r_oslot, r_st});
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("second transaction taken while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |=> r_ovalid)
        else $error("result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> r_n <= w_cap)
        else $error("probe walk exceeded capacity");

endmodule

// ===== dv/tb_linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking testbench for the linear probing hash table. A queue-fed
// driver sends requests in bursts, a monitor checks every response against
// a behavioral copy of the table, and the capacity register is swept
// between phases while the table is idle.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int SLOTS = 256;
    localparam logic [2:0] MD_RSV5 = 3'd5;
    localparam logic [2:0] MD_RSV7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [63:0] key;
        logic [31:0] value;
    } rsp_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel, penable, pwrite;
    logic [0:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // mode[2:0], key[66:3], value[98:67]
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status[2:0], slot[10:3], key_out[74:11], value_out[106:75]
    logic [111:0] m_axis_tdata;

    linear_probe_hash_table uut (.*);

    req_t        req_q[$];
    rsp_t        rsp_q[$];
    req_t        cur_req;
    bit          in_taken;
    int          gap_cnt, burst_cnt, gap_max, stall_level, hold_cnt;
    int          err_cnt, n_items, n_rsp, n_phase;
    int          st_seen[8];

    // table shadow
    logic [1:0]  tbl_mark[SLOTS];
    logic [63:0] tbl_key[SLOTS];
    logic [31:0] tbl_val[SLOTS];
    logic [8:0]  tbl_cnt;
    int          cur_slot;
    bit          cur_ok;
    logic [8:0]  cap_reg;
    logic [63:0] key_pool[12];

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 3_000_000);
        $display("linear_probe_hash_table regression: fail");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (response %0d)", what, got, want, n_rsp);
        err_cnt++;
    endtask

    function automatic void table_op(input req_t rq);
        logic [63:0] k, h, c;
        int ecap, idx, n, tomb, dest;
        bit tomb_seen, done;
        rsp_t r;
        k = 0;
        h = 0;
        r = '0;
        done = 0;
        for (int i = 0; i < 8; i++) begin
            c = (rq.key >> (8 * i)) & 64'hff;
            if (c == 0) break;
            k |= c << (8 * i);
            if (c >= 64'h41 && c <= 64'h5a) c += 64'h20;
            h = h * 33 + c;
        end
        ecap = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
        idx = int'(h % ecap);
        r.status = ST_NO_ENTRY;
        case (rq.mode)
            MD_INSERT: begin
                tomb_seen = 0;
                tomb = 0;
                for (n = 0; n < ecap; n++) begin
                    if (tbl_mark[idx] == MK_EMPTY) break;
                    if (tbl_mark[idx] == MK_TOMB) begin
                        if (!tomb_seen) begin
                            tomb_seen = 1;
                            tomb = idx;
                        end
                    end else if (tbl_key[idx] == k) begin
                        cur_slot = idx;
                        cur_ok = 1;
                        r.status = ST_DUPLICATE;
                        r.slot = 8'(idx);
                        done = 1;
                        break;
                    end
                    idx = (idx + 1) % ecap;
                end
                if (!done) begin
                    if (!tomb_seen && n >= ecap) begin
                        r.status = ST_FULL;
                    end else begin
                        dest = tomb_seen ? tomb : idx;
                        tbl_mark[dest] = MK_USED;
                        tbl_key[dest] = k;
                        tbl_val[dest] = rq.value;
                        tbl_cnt++;
                        cur_slot = dest;
                        cur_ok = 1;
                        r.status = ST_INSERTED;
                        r.slot = 8'(dest);
                    end
                end
            end
            MD_ERASE, MD_SEARCH: begin
                r.status = ST_NOT_FOUND;
                for (n = 0; n < ecap; n++) begin
                    if (tbl_mark[idx] == MK_EMPTY) break;
                    if (tbl_mark[idx] == MK_USED && tbl_key[idx] == k) begin
                        cur_slot = idx;
                        cur_ok = 1;
                        r.slot = 8'(idx);
                        if (rq.mode == MD_ERASE) begin
                            tbl_mark[idx] = MK_TOMB;
                            tbl_cnt--;
                            r.status = ST_ERASED;
                        end else begin
                            r.status = ST_FOUND;
                            r.key = tbl_key[idx];
                            r.value = tbl_val[idx];
                        end
                        break;
                    end
                    idx = (idx + 1) % ecap;
                end
            end
            MD_FIRST: begin
                cur_ok = 0;
                for (int i = 0; i < ecap; i++) begin
                    if (tbl_mark[i] == MK_USED) begin
                        cur_slot = i;
                        cur_ok = 1;
                        r = '{ST_FOUND, 8'(i), tbl_key[i], tbl_val[i]};
                        break;
                    end
                end
            end
            MD_NEXT: begin
                if (cur_ok && cur_slot < ecap) begin
                    for (int i = cur_slot + 1; i < ecap; i++) begin
                        if (tbl_mark[i] == MK_USED) begin
                            cur_slot = i;
                            r = '{ST_FOUND, 8'(i), tbl_key[i], tbl_val[i]};
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        rsp_q.push_back(r);
    endfunction

    // input side: acceptance at the rising edge, new data at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            table_op(cur_req);
            n_items++;
            in_taken = 1;
        end
    end

    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (gap_cnt > 0) begin
                gap_cnt--;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                cur_req = req_q.pop_front();
                s_axis_tdata <= {5'b0, cur_req.value, cur_req.key, cur_req.mode};
                s_axis_tvalid <= 1'b1;
                if (--burst_cnt <= 0) begin
                    burst_cnt = $urandom_range(1, 12);
                    gap_cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        in_taken = 0;
    end

    // output side
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) >= stall_level);
        end
    end

    always @(posedge i_clk) begin
        rsp_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[2:0];
            got.slot   = m_axis_tdata[10:3];
            got.key    = m_axis_tdata[74:11];
            got.value  = m_axis_tdata[106:75];
            n_rsp++;
            st_seen[got.status]++;
            if (rsp_q.size() == 0) begin
                report("unexpected transaction, status", got.status, 0);
            end else begin
                want = rsp_q.pop_front();
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.slot !== want.slot) report("slot", got.slot, want.slot);
                if (got.key !== want.key) report("key_out", got.key, want.key);
                if (got.value !== want.value) report("value_out", got.value, want.value);
            end
        end
    end

    task automatic push(input logic [2:0] m, input logic [63:0] k, input logic [31:0] v);
        req_q.push_back('{m, k, v});
    endtask

    task automatic set_capacity(input logic [8:0] cap);
        @(negedge i_clk);
        psel = 1;
        pwrite = 1;
        paddr = REG_CAPACITY;
        pwdata = {23'd0, cap};
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        cap_reg = cap;
        n_phase++;
    endtask

    task automatic wait_idle();
        while (req_q.size() > 0 || s_axis_tvalid || rsp_q.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        int len;
        k = 0;
        len = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                case ($urandom_range(0, 2))
                    0: k[8*i +: 8] = 8'($urandom_range(8'h41, 8'h5a));
                    1: k[8*i +: 8] = 8'($urandom_range(8'h61, 8'h7a));
                    default: k[8*i +: 8] = 8'($urandom_range(1, 255));
                endcase
            end else if (i > len && $urandom_range(0, 3) == 0) begin
                k[8*i +: 8] = 8'($urandom);
            end
        end
        return k;
    endfunction

    task automatic random_phase(input int cnt);
        logic [63:0] k;
        int sel;
        foreach (key_pool[i]) key_pool[i] = rand_key();
        for (int i = 0; i < cnt; i++) begin
            k = key_pool[$urandom_range(0, 11)];
            sel = $urandom_range(0, 9);
            if (sel == 0) k = rand_key();
            else if (sel == 1) k = k ^ 64'h20;
            sel = $urandom_range(0, 99);
            if (sel < 35) push(MD_INSERT, k, $urandom);
            else if (sel < 55) push(MD_ERASE, k, $urandom);
            else if (sel < 75) push(MD_SEARCH, k, $urandom);
            else if (sel < 83) push(MD_FIRST, k, $urandom);
            else if (sel < 96) push(MD_NEXT, k, $urandom);
            else push(3'($urandom_range(MD_RSV5, MD_RSV7)), k, $urandom);
        end
    endtask

    initial begin
        int caps[9];
        caps = '{2, 7, 256, 0, 16, 511, 3, 64, 256};
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        in_taken = 0;
        gap_cnt = 0;
        burst_cnt = 1;
        gap_max = 4;
        stall_level = 1;
        hold_cnt = 0;
        err_cnt = 0;
        n_items = 0;
        n_rsp = 0;
        n_phase = 0;
        foreach (tbl_mark[i]) tbl_mark[i] = MK_EMPTY;
        tbl_cnt = 0;
        cur_slot = 0;
        cur_ok = 0;
        cap_reg = 256;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        set_capacity(256);

        push(MD_FIRST, 0, 0);
        push(MD_NEXT, 0, 0);
        push(MD_INSERT, 64'h41, 32'hffff_ffff);
        push(MD_INSERT, 64'h41, 32'h1);
        push(MD_INSERT, 64'h0000_ff00_0000_0041, 32'h2);
        push(MD_SEARCH, 64'h61, 0);
        push(MD_INSERT, 64'h61, 0);
        push(MD_SEARCH, 64'h41, 0);
        push(MD_INSERT, 64'hffff_ffff_ffff_ffff, 32'h5a5a_a5a5);
        push(MD_INSERT, 64'h0, 32'h1234);
        push(MD_SEARCH, 64'h0, 0);
        push(MD_FIRST, 0, 0);
        push(MD_NEXT, 0, 0);
        push(MD_NEXT, 0, 0);
        push(MD_NEXT, 0, 0);
        push(MD_NEXT, 0, 0);
        push(MD_ERASE, 64'h41, 0);
        push(MD_ERASE, 64'h41, 0);
        push(MD_SEARCH, 64'h41, 0);
        push(MD_INSERT, 64'h41, 32'h77);
        for (logic [3:0] m = MD_RSV5; m <= MD_RSV7; m++) push(m[2:0], 64'h41, 0);
        wait_idle();

        // single slot: full table, tombstone reuse after a whole round
        set_capacity(1);
        push(MD_INSERT, 64'h6f6f66, 32'h10);
        push(MD_INSERT, 64'h726162, 32'h20);
        push(MD_ERASE, 64'h6f6f66, 0);
        push(MD_INSERT, 64'h726162, 32'h30);
        push(MD_SEARCH, 64'h6f6f66, 0);
        push(MD_NEXT, 0, 0);
        random_phase(20);
        wait_idle();

        foreach (caps[p]) begin
            set_capacity(9'(caps[p]));
            stall_level = p % 4;
            gap_max = (p % 3 == 0) ? 0 : 8;
            random_phase(45);
            if (p == 4) begin
                @(posedge i_clk);
                hold_cnt = 400;
            end
            wait_idle();
        end

        repeat (1200) @(negedge i_clk);
        $display("covered %0d requests over %0d capacity settings", n_items, n_phase);
        $display("responses by status: ins %0d dup %0d era %0d fnd %0d nf %0d full %0d none %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4], st_seen[5],
                 st_seen[6]);
        if (err_cnt == 0 && rsp_q.size() == 0) begin
            $display("linear_probe_hash_table regression: pass");
        end else begin
            $display("linear_probe_hash_table regression: fail");
        end
        $finish;
    end
endmodule
